>>> rtl/core/almt_pkg.sv
// Shared types and constants for the audio level meter and loudness trigger.
package almt_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int THR_W          = 16;
  localparam int SUM_W          = 39;
  localparam int CNT_W          = 8;
  localparam int LED_BAR_W      = 10;
  localparam int LED_CNT_W      = 4;
  localparam int FS_SHIFT       = 31;
  localparam int LEDS_DEF       = 10;
  localparam int MAX_BLOCK_DEF  = 128;

  localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_PREP,
    ST_ITER,
    ST_DONE
  } almt_state_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic iter;
    logic finish;
  } almt_cmd_t;

  typedef struct packed {
    logic block_end;
    logic iter_last;
    logic out_free;
  } almt_sts_t;

endpackage

>>> rtl/core/audio_level_meter_trigger_core.sv
// The result beat is offered once the closing beat has gone through the prepare, compare
// and hand-off states; compare tries one LED count per cycle, hand-off waits for a free
// output register. Samples are taken one a cycle, but only in the accumulate state.
// A finished result waits in the output register while the next block accumulates.
// Reset is asynchronous and active low: it empties the accumulator, drops the output
// beat and restores the loudness threshold to one half of full scale.
module audio_level_meter_trigger_core
  import almt_pkg::*;
#(
  parameter int LEDS      = LEDS_DEF,
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [THR_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LED_BAR_W-1:0] led_bar_o,
  output logic [LED_CNT_W-1:0] led_count_o,
  output logic                 loud_o
);

  // The controller walks through four phases: accumulate, prepare, compare and
  // hand off. Only the accumulate phase takes sample beats; a block closes on a
  // beat marked last or when the sample count reaches MAX_BLOCK.
  almt_cmd_t cmd;
  almt_sts_t sts;

  // Always ready; the user writes the threshold register only while idle; unchecked.
  assign cfg_ready_o = 1'b1;

  almt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the running sum and count, works out the LED count by
  // exact integer comparison of k^2 * n * (2^31 - 1) against LEDS^2 * sum, and
  // compares the sum against the threshold scaled by the same denominator.
  almt_datapath #(
    .LEDS      (LEDS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .led_bar_o   (led_bar_o),
    .led_count_o (led_count_o),
    .loud_o      (loud_o)
  );

  // A new result is only loaded when the previous one has gone or is leaving.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over an untaken result");

  // No sample beat is taken while a block is being evaluated.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.prep || cmd.iter || cmd.finish) |-> !in_ready_o)
    else $error("sample accepted during evaluation");

  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.prep, cmd.iter, cmd.finish}))
    else $error("conflicting datapath commands");

  // A closing beat always leads into the preparation phase.
  a_close_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.block_end) |=> cmd.prep)
    else $error("block close not followed by evaluation");

endmodule

>>> rtl/core/almt_ctrl.sv
// Sequencer for accumulation, block evaluation and result hand-off.
module almt_ctrl
  import almt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  almt_sts_t sts_i,
  output logic      in_ready_o,
  output almt_cmd_t cmd_o
);

  almt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (in_valid_i && sts_i.block_end) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (sts_i.iter_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_ITER: begin
        cmd_o.iter = 1'b1;
      end
      ST_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/almt_datapath.sv
// Accumulator, exact level comparisons and output register of the level meter.
module almt_datapath
  import almt_pkg::*;
#(
  parameter int LEDS      = LEDS_DEF,
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  almt_cmd_t            cmd_i,
  output almt_sts_t            sts_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [LED_BAR_W-1:0] led_bar_o,
  output logic [LED_CNT_W-1:0] led_count_o,
  output logic                 loud_o
);

  localparam int KW      = $clog2(LEDS + 1);
  localparam int EW      = SUM_W + $clog2((LEDS + 1) * (LEDS + 1) + 1);
  localparam int LEDS_SQ = LEDS * LEDS;
  localparam int TN_W    = THR_W + CNT_W;
  localparam int LW      = SUM_W + THR_W;
  localparam int N3_W    = CNT_W + 2;
  localparam int CX_W    = LED_CNT_W + 1;

  logic [THR_W-1:0]     thr_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [EW-1:0]        kk_q, step_q, dbl_q, scaled_q;
  logic [TN_W-1:0]      tn_q;
  logic [KW-1:0]        k_q, count_q;
  logic                 loud_q;
  logic                 out_valid_q;
  logic [LED_BAR_W-1:0] led_bar_q;
  logic [LED_CNT_W-1:0] led_count_q;
  logic                 loud_out_q;

  logic [SAMPLE_W-1:0]  mag_c;
  logic [SUM_W-1:0]     sum_next_c;
  logic [CNT_W-1:0]     cnt_next_c;
  logic [N3_W-1:0]      n3_c;
  logic [EW-1:0]        den_c, step3_c;
  logic [CX_W-1:0]      count_ext_c;
  logic [LED_BAR_W-1:0] bar_c;
  logic                 loud_c;

  // Magnitude of a two's complement sample; the most negative value gives 2^31.
  assign mag_c      = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign sum_next_c = sum_q + SUM_W'(mag_c);
  assign cnt_next_c = cnt_q + 1'b1;

  // Denominator n * (2^31 - 1) and 3n * (2^31 - 1) by shift and subtract.
  assign n3_c    = {1'b0, cnt_q, 1'b0} + N3_W'(cnt_q);
  assign den_c   = (EW'(cnt_q) << FS_SHIFT) - EW'(cnt_q);
  assign step3_c = (EW'(n3_c) << FS_SHIFT) - EW'(n3_c);

  assign loud_c = (LW'(sum_q) << THR_W) > ((LW'(tn_q) << FS_SHIFT) - LW'(tn_q));

  assign count_ext_c = CX_W'(count_q);

  always_comb begin
    for (int i = 0; i < LED_BAR_W; i++) begin
      bar_c[i] = count_ext_c > CX_W'(i);
    end
  end

  assign sts_o.block_end = last_i || (cnt_next_c >= CNT_W'(MAX_BLOCK));
  assign sts_o.iter_last = (k_q == KW'(LEDS));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        sum_q <= sum_next_c;
        cnt_q <= cnt_next_c;
      end else if (cmd_i.finish) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // k^2 * denom is walked up by odd multiples of denom, one candidate a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      kk_q     <= den_c;
      step_q   <= step3_c;
      dbl_q    <= den_c << 1;
      scaled_q <= EW'(sum_q) * EW'(LEDS_SQ);
      tn_q     <= TN_W'(thr_q) * TN_W'(cnt_q);
      k_q      <= KW'(1);
      count_q  <= '0;
    end else if (cmd_i.iter) begin
      if (kk_q <= scaled_q) begin
        count_q <= k_q;
      end
      kk_q   <= kk_q + step_q;
      step_q <= step_q + dbl_q;
      k_q    <= k_q + 1'b1;
      loud_q <= loud_c;
    end
    if (cmd_i.finish) begin
      led_bar_q   <= bar_c;
      led_count_q <= count_ext_c[LED_CNT_W-1:0];
      loud_out_q  <= loud_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_bar_o   = led_bar_q;
  assign led_count_o = led_count_q;
  assign loud_o      = loud_out_q;

endmodule
